@@ rtl/core/bitmap_page_frame_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap page-frame allocator
// Shared property forms, each clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define BPFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap page-frame allocator package
// Sizes, operation codes, shared types and word-level helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = $clog2(WORD_BITS);
  localparam int NUM_WORDS  = MAX_FRAMES / WORD_BITS;
  localparam int WIDX_W     = $clog2(NUM_WORDS);
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = 13;
  localparam int FUNC_W     = 3;
  localparam int ADDR_W     = 32;
  localparam int SUM_W      = ADDR_W + 2;
  localparam int RGN_W      = SUM_W - PAGE_SHIFT;

  localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(4096);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_FRAMES);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC       = 3'd0,
    FUNC_FREE        = 3'd1,
    FUNC_REGION_FREE = 3'd2,
    FUNC_REGION_USED = 3'd3,
    FUNC_ALL_USED    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_CLEAR,
    OP_SET
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 clr_all;
  } bm_cmd_t;

  function automatic logic [WORD_SHIFT:0] popcount_word(input logic [WORD_BITS-1:0] w);
    logic [31:0] x;
    x = w - ((w >> 1) & 32'h5555_5555);
    x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
    x = (x + (x >> 4)) & 32'h0F0F_0F0F;
    x = x + (x >> 8);
    x = x + (x >> 16);
    return x[WORD_SHIFT:0];
  endfunction

  function automatic logic [WORD_SHIFT-1:0] lowest_one(input logic [WORD_BITS-1:0] w);
    logic [WORD_SHIFT-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = WORD_SHIFT'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bpfa_if.sv @@
// ----------------------------------------------------------------------------
// Bitmap page-frame allocator channels
// Valid/ready channels for configuration, requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpfa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bpfa_pkg::CNT_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpfa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bpfa_pkg::FUNC_W-1:0] func;
  logic [bpfa_pkg::ADDR_W-1:0] byte_address;
  logic [bpfa_pkg::ADDR_W-1:0] byte_length;
  modport source (output valid, output func, output byte_address, output byte_length,
                  input ready);
  modport sink   (input valid, input func, input byte_address, input byte_length,
                  output ready);
endinterface

interface bpfa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bpfa_pkg::ADDR_W-1:0] page_address;
  logic                        alloc_ok;
  logic [bpfa_pkg::CNT_W-1:0]  used_count;
  logic [bpfa_pkg::CNT_W-1:0]  free_count;
  modport source (output valid, output page_address, output alloc_ok, output used_count,
                  output free_count, input ready);
  modport sink   (input valid, input page_address, input alloc_ok, input used_count,
                  input free_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bpfa_bitmap.sv @@
// ----------------------------------------------------------------------------
// Bitmap page-frame allocator word store
// Used-bit memory in 32-bit words with a row valid bit that reads unwritten
// or bulk-cleared rows as all used.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_bitmap (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bpfa_pkg::bm_cmd_t                   cmd,
  output logic       [bpfa_pkg::WORD_BITS-1:0]     rd_data
);

  logic [bpfa_pkg::WORD_BITS-1:0] mem [bpfa_pkg::NUM_WORDS];
  logic [bpfa_pkg::NUM_WORDS-1:0] row_valid;
  logic [bpfa_pkg::WORD_BITS-1:0] mem_q;
  logic                           valid_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (cmd.clr_all) begin
        row_valid <= '0;
      end else if (cmd.wr_en) begin
        row_valid[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        valid_q <= row_valid[cmd.rd_addr];
      end
    end
  end

  assign rd_data = valid_q ? mem_q : '1;

endmodule

`default_nettype wire

@@ rtl/core/bitmap_page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap page-frame allocator
// One used bit per 4 KiB frame, held in a 128 x 32-bit memory, with a used
// frame counter. Allocate returns the lowest free frame below the configured
// total; free, mark region free, mark region used and mark all used update
// the map, and every request gets one response with the counts. Allocate
// and the region operations walk the map one word per cycle through the
// memory's single read port; mark all used and an empty region skip the
// walk. One request is in work at a time; a finished response waits in an
// output register while the next request is taken. Reset needs no clearing
// pass: row valid bits make the map read as all used at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_page_frame_allocator_defines.svh"

module bitmap_page_frame_allocator (
  input wire logic   clk,
  input wire logic   rst,
  bpfa_cfg_if.sink   cfg,
  bpfa_req_if.sink   req,
  bpfa_rsp_if.source rsp
);

  bpfa_pkg::state_t                   state, state_next;
  bpfa_pkg::op_t                      op, dec_op;
  logic [bpfa_pkg::CNT_W-1:0]         frames_in_use;
  logic [bpfa_pkg::CNT_W-1:0]         tot;
  logic [bpfa_pkg::CNT_W-1:0]         used;
  logic [bpfa_pkg::WIDX_W-1:0]        first_word, last_word, rd_word, p_word;
  logic [bpfa_pkg::WORD_SHIFT-1:0]    lo_off, hi_off;
  logic                               rd_done, p_vld;
  logic                               d_vld, d_up;
  logic [bpfa_pkg::WORD_SHIFT:0]      d_cnt;
  logic                               res_ok;
  logic [bpfa_pkg::ADDR_W-1:0]        res_addr;
  logic                               accept, issue, load_rsp, go_scan, all_used;
  logic                               dec_scan, empty, hit, wr_word;
  logic [bpfa_pkg::SUM_W-1:0]         addr_x, sum_x, addr_up, sum_up;
  logic [bpfa_pkg::RGN_W-1:0]         rgn_start, rgn_end;
  logic [bpfa_pkg::CNT_W-1:0]         end_c, last_f;
  logic [bpfa_pkg::WORD_BITS-1:0]     cur, mask, lo_mask, hi_mask, cand, new_word, changed;
  logic [bpfa_pkg::WORD_SHIFT-1:0]    hit_idx;
  logic [bpfa_pkg::CNT_W:0]           up_sum;
  logic [bpfa_pkg::WORD_BITS-1:0]     rd_data_w;
  bpfa_pkg::bm_cmd_t                  bm_cmd;
  logic                               scan_vld, word_ok, rsp_held, in_done, used_ok, busy;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == bpfa_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= bpfa_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      frames_in_use <= cfg.data;
    end
  end

  assign tot = (frames_in_use > bpfa_pkg::MAX_CNT) ? bpfa_pkg::MAX_CNT : frames_in_use;

  // Request decode: region bounds in frames, taken wide and then clamped.
  always_comb begin
    addr_x    = bpfa_pkg::SUM_W'(req.byte_address);
    sum_x     = addr_x + bpfa_pkg::SUM_W'(req.byte_length);
    addr_up   = addr_x + bpfa_pkg::SUM_W'(bpfa_pkg::PAGE_BYTES - 1);
    sum_up    = sum_x + bpfa_pkg::SUM_W'(bpfa_pkg::PAGE_BYTES - 1);
    rgn_start = '0;
    rgn_end   = '0;
    dec_op    = bpfa_pkg::OP_ALLOC;
    dec_scan  = 1'b0;
    all_used  = 1'b0;
    unique case (req.func)
      bpfa_pkg::FUNC_ALLOC: begin
        rgn_end  = bpfa_pkg::RGN_W'(tot);
        dec_scan = 1'b1;
      end
      bpfa_pkg::FUNC_FREE: begin
        rgn_start = bpfa_pkg::RGN_W'(addr_x >> bpfa_pkg::PAGE_SHIFT);
        rgn_end   = rgn_start + bpfa_pkg::RGN_W'(1);
        dec_op    = bpfa_pkg::OP_CLEAR;
        dec_scan  = 1'b1;
      end
      bpfa_pkg::FUNC_REGION_FREE: begin
        rgn_start = bpfa_pkg::RGN_W'(addr_up >> bpfa_pkg::PAGE_SHIFT);
        rgn_end   = bpfa_pkg::RGN_W'(sum_x >> bpfa_pkg::PAGE_SHIFT);
        dec_op    = bpfa_pkg::OP_CLEAR;
        dec_scan  = 1'b1;
      end
      bpfa_pkg::FUNC_REGION_USED: begin
        rgn_start = bpfa_pkg::RGN_W'(addr_x >> bpfa_pkg::PAGE_SHIFT);
        rgn_end   = bpfa_pkg::RGN_W'(sum_up >> bpfa_pkg::PAGE_SHIFT);
        dec_op    = bpfa_pkg::OP_SET;
        dec_scan  = 1'b1;
      end
      bpfa_pkg::FUNC_ALL_USED: begin
        all_used = 1'b1;
      end
      default: begin
        dec_scan = 1'b0;
      end
    endcase
    end_c   = (rgn_end > bpfa_pkg::RGN_W'(tot)) ? tot : rgn_end[bpfa_pkg::CNT_W-1:0];
    empty   = (rgn_start >= bpfa_pkg::RGN_W'(end_c));
    go_scan = dec_scan && !empty;
    last_f  = end_c - bpfa_pkg::CNT_W'(1);
  end

  // Word processing on the data returned by the map.
  always_comb begin
    cur     = rd_data_w;
    lo_mask = (p_word == first_word) ? ('1 << lo_off) : '1;
    hi_mask = (p_word == last_word)
              ? ('1 >> (bpfa_pkg::WORD_SHIFT'(bpfa_pkg::WORD_BITS - 1) - hi_off)) : '1;
    mask    = lo_mask & hi_mask;
    cand    = ~cur & mask;
    hit_idx = bpfa_pkg::lowest_one(cand);
    hit     = (op == bpfa_pkg::OP_ALLOC) && (cand != '0);
    unique case (op)
      bpfa_pkg::OP_ALLOC: begin
        new_word = cur | (bpfa_pkg::WORD_BITS'(1) << hit_idx);
        changed  = '0;
      end
      bpfa_pkg::OP_SET: begin
        new_word = cur | mask;
        changed  = mask & ~cur;
      end
      bpfa_pkg::OP_CLEAR: begin
        new_word = cur & ~mask;
        changed  = mask & cur;
      end
      default: begin
        new_word = cur;
        changed  = '0;
      end
    endcase
    wr_word = (state == bpfa_pkg::ST_SCAN) && p_vld && ((op != bpfa_pkg::OP_ALLOC) || hit);
  end

  always_comb begin
    bm_cmd.rd_en   = issue;
    bm_cmd.rd_addr = rd_word;
    bm_cmd.wr_en   = wr_word;
    bm_cmd.wr_addr = p_word;
    bm_cmd.wr_data = new_word;
    bm_cmd.clr_all = accept && all_used;
  end

  bpfa_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .cmd     (bm_cmd),
    .rd_data (rd_data_w)
  );

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    load_rsp   = 1'b0;
    unique case (state)
      bpfa_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = go_scan ? bpfa_pkg::ST_SCAN : bpfa_pkg::ST_DONE;
        end
      end
      bpfa_pkg::ST_SCAN: begin
        issue = !rd_done;
        if (p_vld && (hit || (p_word == last_word))) begin
          state_next = bpfa_pkg::ST_DRAIN;
        end
      end
      bpfa_pkg::ST_DRAIN: begin
        state_next = bpfa_pkg::ST_DONE;
      end
      bpfa_pkg::ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = bpfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bpfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpfa_pkg::ST_IDLE;
      p_vld <= 1'b0;
      d_vld <= 1'b0;
    end else begin
      state <= state_next;
      p_vld <= issue;
      d_vld <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= dec_op;
      first_word <= rgn_start[bpfa_pkg::FRAME_W-1:bpfa_pkg::WORD_SHIFT];
      lo_off     <= rgn_start[bpfa_pkg::WORD_SHIFT-1:0];
      last_word  <= last_f[bpfa_pkg::FRAME_W-1:bpfa_pkg::WORD_SHIFT];
      hi_off     <= last_f[bpfa_pkg::WORD_SHIFT-1:0];
      rd_word    <= rgn_start[bpfa_pkg::FRAME_W-1:bpfa_pkg::WORD_SHIFT];
      rd_done    <= 1'b0;
      res_ok     <= 1'b0;
      res_addr   <= '0;
    end else begin
      if (issue) begin
        rd_word <= rd_word + bpfa_pkg::WIDX_W'(1);
        rd_done <= (rd_word == last_word);
      end
      if ((state == bpfa_pkg::ST_SCAN) && p_vld && hit) begin
        res_ok   <= 1'b1;
        res_addr <= bpfa_pkg::ADDR_W'({p_word, hit_idx}) << bpfa_pkg::PAGE_SHIFT;
      end
    end
    p_word <= rd_word;
    d_up   <= (op != bpfa_pkg::OP_CLEAR);
    d_cnt  <= (op == bpfa_pkg::OP_ALLOC) ? (bpfa_pkg::WORD_SHIFT + 1)'(1)
                                         : bpfa_pkg::popcount_word(changed);
  end

  assign up_sum = {1'b0, used} + (bpfa_pkg::CNT_W + 1)'(d_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= bpfa_pkg::CFG_RESET;
    end else if (accept && all_used) begin
      used <= tot;
    end else if (d_vld) begin
      if (d_up) begin
        used <= (up_sum > (bpfa_pkg::CNT_W + 1)'(bpfa_pkg::MAX_CNT))
                ? bpfa_pkg::MAX_CNT : up_sum[bpfa_pkg::CNT_W-1:0];
      end else begin
        used <= (used > bpfa_pkg::CNT_W'(d_cnt)) ? used - bpfa_pkg::CNT_W'(d_cnt) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.page_address <= res_addr;
      rsp.alloc_ok     <= res_ok;
      rsp.used_count   <= used;
      rsp.free_count   <= (tot > used) ? tot - used : '0;
    end
  end

  assign scan_vld = (state == bpfa_pkg::ST_SCAN) && p_vld;
  assign word_ok  = (p_word >= first_word) && (p_word <= last_word);
  assign rsp_held = (state == bpfa_pkg::ST_DONE) && rsp.valid && !rsp.ready;
  assign in_done  = (state == bpfa_pkg::ST_DONE);
  assign used_ok  = (used <= bpfa_pkg::MAX_CNT);
  assign busy     = (state != bpfa_pkg::ST_IDLE);

  `BPFA_ASSERT_NOW(a_used_range, clk, rst, 1'b1, used_ok, "used count above frame limit")
  `BPFA_ASSERT_NOW(a_word_in_range, clk, rst, scan_vld, word_ok, "scanned word outside region")
  `BPFA_ASSERT_NEXT(a_leave_idle, clk, rst, accept, busy, "accepted request did not start")
  `BPFA_ASSERT_NEXT(a_done_holds, clk, rst, rsp_held, in_done, "stalled response lost")

endmodule

`default_nettype wire
